// ----- sv/quadrature_encoder_speed_meter_core_macros.svh -----
// Assertion macros shared by the encoder speed meter RTL.
// Each macro checks on the rising edge of clock and is off while reset is high.
`ifndef QUADRATURE_ENCODER_SPEED_METER_CORE_MACROS_SVH
`define QUADRATURE_ENCODER_SPEED_METER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition that must hold at every edge
`define QESM_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define QESM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define QESM_ASSERT_ALWAYS(label, cond, msg)
`define QESM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- sv/qesm_pkg.sv -----
package qesm_pkg;

   // Width of the wrapping position counter (8 to 32)
   localparam int CountWidth = 32;

   // Configuration port
   localparam int CsrDataWidth  = 32;
   localparam int CsrAddrWidth  = 3;
   localparam int CsrIndexWidth = CsrAddrWidth - 2;
   localparam int ScaleWidth    = 16;
   localparam logic [ScaleWidth-1:0] ScaleReset = 16'd1920;

   // Register indexes
   localparam logic [CsrIndexWidth-1:0] RegRpmPerCountQ8 = 1'b0;

   // Result field widths
   localparam int PosWidth   = 32;
   localparam int SpeedWidth = 48;

   typedef struct packed {
      logic chan_a;
      logic chan_b;
      logic window_tick;
   } qesm_req_type;

   typedef struct packed {
      logic signed [PosWidth-1:0]   position_count;
      logic signed [PosWidth-1:0]   count_delta;
      logic signed [SpeedWidth-1:0] speed_rpm_q8;
      logic                         speed_updated;
   } qesm_rsp_type;

endpackage

// ----- sv/quadrature_encoder_speed_meter_core.sv -----
// Quadrature encoder counter with windowed speed measurement.
// Each accepted item passes through three registers (input register, decode/count
// register, multiply/result register); the count state updates in the second.
// Throughput: one transaction per cycle unless rsp_stall holds the pipeline.
// Reset (synchronous, active high): pipeline empty, counters and speed cleared,
// channel levels unprimed, rpm_per_count_q8 back to 1920.
`include "quadrature_encoder_speed_meter_core_macros.svh"

module quadrature_encoder_speed_meter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  qesm_pkg::qesm_req_type               req_data,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output qesm_pkg::qesm_rsp_type               rsp_data,
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [qesm_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [qesm_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [qesm_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   localparam int CW = qesm_pkg::CountWidth;
   localparam int PW = qesm_pkg::PosWidth;
   localparam int SW = qesm_pkg::SpeedWidth;
   localparam int KW = qesm_pkg::ScaleWidth;

   // Configuration register
   logic [KW-1:0] scale_ff, scale_in;
   logic [qesm_pkg::CsrIndexWidth-1:0] csr_index;
   logic csr_write;

   // Pipeline control
   logic s0_valid_ff, s0_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic load0, load1, load2;

   // Stage payloads
   qesm_pkg::qesm_req_type s0_data_ff;
   logic signed [PW-1:0] s1_pos_ff, s1_pos_in;
   logic signed [PW-1:0] s1_delta_ff;
   logic                 s1_tick_ff;
   qesm_pkg::qesm_rsp_type rsp_data_ff, rsp_data_in;

   // Decoder and window state
   logic          primed_ff, primed_in;
   logic          prev_a_ff, prev_a_in;
   logic          prev_b_ff, prev_b_in;
   logic [CW-1:0] edge_count_ff, edge_count_in;
   logic [CW-1:0] start_count_ff, start_count_in;
   logic signed [PW-1:0] last_delta_ff, last_delta_in;
   logic signed [SW-1:0] last_speed_ff, last_speed_in;

   logic [CW-1:0] delta_raw;
   logic signed [SW-1:0] product;

   // Check helpers
   logic [CW-1:0] count_move;
   logic          speed_same;

   // Configuration access
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[qesm_pkg::CsrAddrWidth-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      scale_in = scale_ff;
      if (csr_write && (csr_index == qesm_pkg::RegRpmPerCountQ8)) begin
         scale_in = csr_pwdata[KW-1:0];
      end
   end

   always_comb begin
      unique case (csr_index)
         qesm_pkg::RegRpmPerCountQ8: csr_prdata = qesm_pkg::CsrDataWidth'(scale_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // Pipeline advance: each stage loads when empty or draining
   assign load2 = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign load1 = s0_valid_ff && (!s1_valid_ff || load2);
   assign req_stall = s0_valid_ff && !load1;
   assign load0 = req_valid && !req_stall;

   assign s0_valid_in  = load0 || (s0_valid_ff && !load1);
   assign s1_valid_in  = load1 || (s1_valid_ff && !load2);
   assign rsp_valid_in = load2 || (rsp_valid_ff && rsp_stall);

   // Quadrature decode and window update
   always_comb begin
      primed_in      = primed_ff;
      prev_a_in      = prev_a_ff;
      prev_b_in      = prev_b_ff;
      edge_count_in  = edge_count_ff;
      start_count_in = start_count_ff;
      last_delta_in  = last_delta_ff;

      if (!primed_ff) begin
         prev_a_in = s0_data_ff.chan_a;
         prev_b_in = s0_data_ff.chan_b;
         primed_in = 1'b1;
      end else if (s0_data_ff.chan_a != prev_a_ff) begin
         // A edge takes priority
         if (s0_data_ff.chan_a != s0_data_ff.chan_b) begin
            edge_count_in = edge_count_ff + CW'(1);
         end else begin
            edge_count_in = edge_count_ff - CW'(1);
         end
         prev_a_in = s0_data_ff.chan_a;
      end else if (s0_data_ff.chan_b != prev_b_ff) begin
         if (s0_data_ff.chan_a == s0_data_ff.chan_b) begin
            edge_count_in = edge_count_ff + CW'(1);
         end else begin
            edge_count_in = edge_count_ff - CW'(1);
         end
         prev_b_in = s0_data_ff.chan_b;
      end

      delta_raw = edge_count_in - start_count_ff;
      if (s0_data_ff.window_tick) begin
         last_delta_in  = PW'($signed(delta_raw));
         start_count_in = edge_count_in;
      end

      s1_pos_in = PW'($signed(edge_count_in));
   end

   // Speed multiply and result assembly; the exact product fits in SW bits
   always_comb begin
      product = $signed(s1_delta_ff) * $signed({1'b0, scale_ff});
      last_speed_in = last_speed_ff;
      if (s1_tick_ff) begin
         last_speed_in = product;
      end
      rsp_data_in.position_count = s1_pos_ff;
      rsp_data_in.count_delta    = s1_delta_ff;
      rsp_data_in.speed_rpm_q8   = last_speed_in;
      rsp_data_in.speed_updated  = s1_tick_ff;
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff       <= qesm_pkg::ScaleReset;
         s0_valid_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         primed_ff      <= 1'b0;
         prev_a_ff      <= 1'b0;
         prev_b_ff      <= 1'b0;
         edge_count_ff  <= '0;
         start_count_ff <= '0;
         last_delta_ff  <= '0;
         last_speed_ff  <= '0;
      end else begin
         scale_ff     <= scale_in;
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load1) begin
            primed_ff      <= primed_in;
            prev_a_ff      <= prev_a_in;
            prev_b_ff      <= prev_b_in;
            edge_count_ff  <= edge_count_in;
            start_count_ff <= start_count_in;
            last_delta_ff  <= last_delta_in;
         end
         if (load2) begin
            last_speed_ff <= last_speed_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (load0) begin
         s0_data_ff <= req_data;
      end
      if (load1) begin
         s1_pos_ff   <= s1_pos_in;
         s1_delta_ff <= last_delta_in;
         s1_tick_ff  <= s0_data_ff.window_tick;
      end
      if (load2) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   assign count_move = edge_count_in - edge_count_ff + CW'(1);
   assign speed_same = (rsp_data_ff.speed_rpm_q8 == last_speed_ff);

   `QESM_ASSERT_ALWAYS(a_stall_needs_item, !req_stall || s0_valid_ff, "stall while empty")
   `QESM_ASSERT_NEXT(a_count_holds, !load1, $stable(edge_count_ff), "count moved while idle")
   `QESM_ASSERT_NEXT(a_prime_hold, load1 && !primed_ff, $stable(edge_count_ff), "priming counted")
   `QESM_ASSERT_ALWAYS(a_count_step, !load1 || (count_move <= CW'(2)), "count step over one")
   `QESM_ASSERT_ALWAYS(a_speed_matches, !rsp_valid_ff || speed_same, "speed differs from held")

endmodule
